>>> hw/rtl/ttps_pkg.sv
// ----------------------------------------------------------------------------
// ttps_pkg
// Shared types and constants of the transposition table probe store: field
// widths, stream packing offsets, command and bound kind codes, the table
// entry layout and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ttps_pkg;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int SCORE_W = 16;
  localparam int DEPTH_W = 6;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;

  // Default table size
  localparam int TABLE_ENTRIES = 1024;

  // Key bits folded into the index remainder per cycle
  localparam int BITS_PER_CYCLE = 8;

  // Input tdata layout, lowest bit first
  localparam int KEY_LSB   = 0;
  localparam int ALPHA_LSB = KEY_LSB + KEY_W;
  localparam int BETA_LSB  = ALPHA_LSB + SCORE_W;
  localparam int DEPTH_LSB = BETA_LSB + SCORE_W;
  localparam int SCORE_LSB = DEPTH_LSB + DEPTH_W;
  localparam int IN_USED_W = SCORE_LSB + SCORE_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // Input tuser layout, lowest bit first
  localparam int CMD_LSB    = 0;
  localparam int KIND_LSB   = CMD_LSB + CMD_W;
  localparam int IN_TUSER_W = KIND_LSB + KIND_W;

  // Output channel
  localparam int OUT_TDATA_W = SCORE_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PROBE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Bound kind codes
  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

  // One table entry
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [KIND_W-1:0]         kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/ttps_ram.sv
// ----------------------------------------------------------------------------
// ttps_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ttps_index.sv
// ----------------------------------------------------------------------------
// ttps_index
// Table index unit: reduces the 64-bit key modulo the table size. A power of
// two size takes the low key bits into a register; any other size runs a
// restoring remainder over the key, several key bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_index #(
  parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [ttps_pkg::KEY_W-1:0]       key,
  output logic                                  done,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      index
);

  localparam int  IW   = $clog2(TABLE_ENTRIES);
  localparam bit  POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  generate
    if (POW2) begin : g_pow2
      logic          done_r;
      logic [IW-1:0] index_r;

      // Flag the index in the cycle after start
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      // Take the low key bits
      always_ff @(posedge clk) begin
        if (start) begin
          index_r <= key[IW-1:0];
        end
      end

      assign done  = done_r;
      assign index = index_r;
    end else begin : g_mod
      localparam int STEP_CYCLES = ttps_pkg::KEY_W / ttps_pkg::BITS_PER_CYCLE;
      localparam int CNT_W       = (STEP_CYCLES > 1) ? $clog2(STEP_CYCLES) : 1;
      localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEP_CYCLES - 1);
      localparam logic [IW:0]      N_EXT    = (IW + 1)'(TABLE_ENTRIES);

      logic                         busy_r;
      logic                         done_r;
      logic [CNT_W-1:0]             cnt_r;
      logic [IW-1:0]                rem_r;
      logic [IW-1:0]                rem_nxt;
      logic [ttps_pkg::KEY_W-1:0]   key_sh_r;
      logic [ttps_pkg::KEY_W-1:0]   key_sh_nxt;

      // Fold the next key bits into the remainder, most significant first
      always_comb begin
        logic [IW:0]                t;
        logic [IW-1:0]              rem_v;
        logic [ttps_pkg::KEY_W-1:0] sh_v;
        rem_v = rem_r;
        sh_v  = key_sh_r;
        for (int i = 0; i < ttps_pkg::BITS_PER_CYCLE; i++) begin
          t    = {rem_v, sh_v[ttps_pkg::KEY_W-1]};
          sh_v = sh_v << 1;
          if (t >= N_EXT) begin
            t = t - N_EXT;
          end
          rem_v = t[IW-1:0];
        end
        rem_nxt    = rem_v;
        key_sh_nxt = sh_v;
      end

      // Sequence the reduction
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            cnt_r  <= CNT_LAST;
          end else if (busy_r) begin
            if (cnt_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r - 1'b1;
            end
          end
        end
      end

      // Hold the remainder and the key being shifted out
      always_ff @(posedge clk) begin
        if (start) begin
          rem_r    <= '0;
          key_sh_r <= key;
        end else if (busy_r) begin
          rem_r    <= rem_nxt;
          key_sh_r <= key_sh_nxt;
        end
      end

      assign done  = done_r;
      assign index = rem_r;
    end
  endgenerate

endmodule

`default_nettype wire

>>> hw/rtl/transposition_table_probe_store.sv
// ----------------------------------------------------------------------------
// transposition_table_probe_store
// Direct-mapped transposition table with always-replace stores, probed and
// written over stream channels.
// ----------------------------------------------------------------------------
// The table holds TABLE_ENTRIES entries in one synchronous RAM, indexed by
// the position key modulo TABLE_ENTRIES and tagged with the full key. Each
// item is handled alone: a probe or store passes through accept, index,
// read or write and result. For a table size that is not a power of two
// the index unit folds 8 key bits per cycle into the remainder.
// Every item gives exactly one result item; stores, clears and unused
// commands return hit 0 and score 0. After reset and after each clear item
// the block sweeps the RAM one entry per cycle over all TABLE_ENTRIES entries, and
// holds in_tready low meanwhile. A finished result waits in an output
// register, so the next item is taken while the result is still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module transposition_table_probe_store #(
  parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // key, alpha_bound, beta_bound, search_depth, store_score, zero pad
  input  wire logic [ttps_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd, store_kind
  input  wire logic [ttps_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // result_score
  output logic [ttps_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // hit
  output logic                                     out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  ttps_pkg::state_t state_r, state_nxt;

  // Captured item
  logic [ttps_pkg::CMD_W-1:0]          cmd_r;
  logic [ttps_pkg::KEY_W-1:0]          key_r;
  logic signed [ttps_pkg::SCORE_W-1:0] alpha_r;
  logic signed [ttps_pkg::SCORE_W-1:0] beta_r;
  logic [ttps_pkg::DEPTH_W-1:0]        depth_r;
  logic signed [ttps_pkg::SCORE_W-1:0] score_r;
  logic [ttps_pkg::KIND_W-1:0]         kind_r;

  logic            in_acc;
  logic            idx_done;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   clr_idx_r, clr_idx_nxt;

  logic            ram_wr_en;
  logic [IW-1:0]   ram_wr_addr;
  ttps_pkg::entry_t ram_wr_data;
  logic            ram_rd_en;
  ttps_pkg::entry_t ram_rd_data;

  logic            out_free;
  logic            out_load;
  logic            out_valid_r;
  logic            out_hit_r, out_hit_nxt;
  logic signed [ttps_pkg::SCORE_W-1:0] out_score_r, out_score_nxt;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Index unit
  ttps_index #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_index (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .key   (in_tdata[ttps_pkg::KEY_LSB +: ttps_pkg::KEY_W]),
    .done  (idx_done),
    .index (idx)
  );

  // Entry store
  ttps_ram #(
    .WIDTH (ttps_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx),
    .rd_data (ram_rd_data)
  );

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_tuser[ttps_pkg::CMD_LSB +: ttps_pkg::CMD_W];
      kind_r  <= in_tuser[ttps_pkg::KIND_LSB +: ttps_pkg::KIND_W];
      key_r   <= in_tdata[ttps_pkg::KEY_LSB +: ttps_pkg::KEY_W];
      alpha_r <= in_tdata[ttps_pkg::ALPHA_LSB +: ttps_pkg::SCORE_W];
      beta_r  <= in_tdata[ttps_pkg::BETA_LSB +: ttps_pkg::SCORE_W];
      depth_r <= in_tdata[ttps_pkg::DEPTH_LSB +: ttps_pkg::DEPTH_W];
      score_r <= in_tdata[ttps_pkg::SCORE_LSB +: ttps_pkg::SCORE_W];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttps_pkg::ST_CLEAR: begin
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = ttps_pkg::ST_IDLE;
        end
      end
      ttps_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ttps_pkg::ST_INDEX;
        end
      end
      ttps_pkg::ST_INDEX: begin
        if (idx_done) begin
          state_nxt = ttps_pkg::ST_DECIDE;
        end
      end
      ttps_pkg::ST_DECIDE: begin
        if (out_free) begin
          state_nxt = (cmd_r == ttps_pkg::CMD_CLEAR) ? ttps_pkg::ST_CLEAR
                                                     : ttps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ttps_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the controller: handshake, RAM access, sweep count
  always_comb begin
    in_tready   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx;
    ram_wr_data = '0;
    out_load    = 1'b0;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      ttps_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      ttps_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      ttps_pkg::ST_INDEX: begin
        ram_rd_en = idx_done && (cmd_r == ttps_pkg::CMD_PROBE);
      end
      ttps_pkg::ST_DECIDE: begin
        out_load = out_free;
        if (out_free && (cmd_r == ttps_pkg::CMD_STORE)) begin
          ram_wr_en         = 1'b1;
          ram_wr_data.key   = key_r;
          ram_wr_data.score = score_r;
          ram_wr_data.depth = depth_r;
          ram_wr_data.kind  = kind_r;
        end
        clr_idx_nxt = '0;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Evaluate the probe against the stored entry
  always_comb begin
    out_hit_nxt   = 1'b0;
    out_score_nxt = '0;
    if ((cmd_r == ttps_pkg::CMD_PROBE) && (ram_rd_data.key == key_r) &&
        (ram_rd_data.depth >= depth_r)) begin
      priority if (ram_rd_data.kind == ttps_pkg::KIND_EXACT) begin
        out_hit_nxt   = 1'b1;
        out_score_nxt = ram_rd_data.score;
      end else if ((ram_rd_data.kind == ttps_pkg::KIND_UPPER) &&
                   (ram_rd_data.score <= alpha_r)) begin
        out_hit_nxt   = 1'b1;
        out_score_nxt = alpha_r;
      end else if ((ram_rd_data.kind == ttps_pkg::KIND_LOWER) &&
                   (ram_rd_data.score >= beta_r)) begin
        out_hit_nxt   = 1'b1;
        out_score_nxt = beta_r;
      end else begin
        out_hit_nxt = 1'b0;
      end
    end
  end

  // Controller registers; reset starts a sweep of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ttps_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Result valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r   <= out_hit_nxt;
      out_score_r <= out_score_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_score_r;

endmodule

`default_nettype wire

>>> hw/rtl/ttps_checker.sv
// ----------------------------------------------------------------------------
// ttps_checker
// Port-level checks of the transposition table probe store, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [ttps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                              out_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser))
    else $error("result changed while stalled");

  // A result without a hit carries a zero score
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero score");

  // The table sweep after reset blocks input
  a_reset_sweep: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_tready)
    else $error("input ready during reset sweep");

  // One item at a time: busy right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

endmodule

bind transposition_table_probe_store ttps_checker u_ttps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
